// ===== sv/svna_pkg.sv =====
// ----------------------------------------------------------------------------
// svna_pkg
// shared types and constants of the smooth vertex normal accumulator
// ----------------------------------------------------------------------------
`default_nettype none

package svna_pkg;

	// default sizes of the stores and data paths
	localparam int VERTEX_SLOTS_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;
	localparam int SUM_BITS_DEF     = 48;

	// fixed port widths
	localparam int INDEX_BITS = 10;
	localparam int OUT_BITS   = 16;

	// unit length in signed Q1.14
	localparam logic signed [OUT_BITS-1:0] UNIT_Q14 = 16'sd16384;

	// command codes
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_RESOLVE = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// ===== sv/svna_ram.sv =====
// ----------------------------------------------------------------------------
// svna_ram
// generic single-clock ram, one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module svna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/svna_norm.sv =====
// ----------------------------------------------------------------------------
// svna_norm
// iterative normaliser: scales a non-zero sum vector and returns Q1.14 unit
// components through a bit-serial square root and a shared restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module svna_norm #(
	parameter int SUM_BITS = svna_pkg::SUM_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [SUM_BITS-1:0]           sum_x,
	input  wire logic signed [SUM_BITS-1:0]           sum_y,
	input  wire logic signed [SUM_BITS-1:0]           sum_z,
	output logic                                      done,
	output logic signed [svna_pkg::OUT_BITS-1:0]      q_x,
	output logic signed [svna_pkg::OUT_BITS-1:0]      q_y,
	output logic signed [svna_pkg::OUT_BITS-1:0]      q_z
);

	localparam int MW = SUM_BITS;
	localparam int OB = svna_pkg::OUT_BITS;

	typedef enum logic [2:0] {
		N_IDLE, N_MAX, N_SCALE, N_SQ, N_SUM, N_ROOT, N_DLOAD, N_DIV
	} nstate_t;

	nstate_t          state_q;
	logic [MW-1:0]    m_q [3];
	logic [MW-1:0]    mm_q;
	logic [2:0]       neg_q;
	logic [59:0]      sq_q [3];
	logic [63:0]      rem_q;
	logic [63:0]      root_q;
	logic [63:0]      bit_q;
	logic [46:0]      r_q;
	logic [46:0]      d_q;
	logic [14:0]      qt_q;
	logic [3:0]       step_q;
	logic [1:0]       comp_q;
	logic [OB-1:0]    res_q [3];

	// combinational helpers
	logic [63:0]      trial;
	logic [MW-1:0]    mag_x, mag_y, mag_z;
	logic [MW-1:0]    mxy;
	logic [30:0]      len;
	logic [29:0]      m_sel;
	logic             ge;
	logic [OB-1:0]    qfull;
	logic [OB-1:0]    qclamp;

	always_comb begin
		trial  = root_q + bit_q;
		mag_x  = sum_x[MW-1] ? MW'(-sum_x) : MW'(sum_x);
		mag_y  = sum_y[MW-1] ? MW'(-sum_y) : MW'(sum_y);
		mag_z  = sum_z[MW-1] ? MW'(-sum_z) : MW'(sum_z);
		mxy    = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		len    = root_q[30:0];
		m_sel  = m_q[comp_q][29:0];
		ge     = (r_q >= d_q);
		qfull  = {qt_q, ge};
		qclamp = ($signed(qfull) > svna_pkg::UNIT_Q14) ? svna_pkg::UNIT_Q14 : qfull;
	end

	// sequencer: scale, sum of squares, square root, three divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done    <= 1'b0;
			comp_q  <= '0;
			step_q  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						m_q[0]  <= mag_x;
						m_q[1]  <= mag_y;
						m_q[2]  <= mag_z;
						neg_q   <= {sum_z[MW-1], sum_y[MW-1], sum_x[MW-1]};
						state_q <= N_MAX;
					end
				end
				N_MAX: begin
					mm_q    <= (m_q[2] > mxy) ? m_q[2] : mxy;
					state_q <= N_SCALE;
				end
				N_SCALE: begin
					// one step a cycle until the largest lies in [2^29, 2^30)
					if (mm_q[MW-1:30] != '0) begin
						m_q[0] <= m_q[0] >> 1;
						m_q[1] <= m_q[1] >> 1;
						m_q[2] <= m_q[2] >> 1;
						mm_q   <= mm_q >> 1;
					end else if (!mm_q[29]) begin
						m_q[0] <= m_q[0] << 1;
						m_q[1] <= m_q[1] << 1;
						m_q[2] <= m_q[2] << 1;
						mm_q   <= mm_q << 1;
					end else begin
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					sq_q[0] <= 60'(m_q[0][29:0]) * 60'(m_q[0][29:0]);
					sq_q[1] <= 60'(m_q[1][29:0]) * 60'(m_q[1][29:0]);
					sq_q[2] <= 60'(m_q[2][29:0]) * 60'(m_q[2][29:0]);
					state_q <= N_SUM;
				end
				N_SUM: begin
					rem_q   <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
					root_q  <= '0;
					bit_q   <= 64'h4000_0000_0000_0000;
					state_q <= N_ROOT;
				end
				N_ROOT: begin
					// digit-by-digit square root, one result bit a cycle
					if (bit_q == '0) begin
						comp_q  <= '0;
						state_q <= N_DLOAD;
					end else begin
						if (rem_q >= trial) begin
							rem_q  <= rem_q - trial;
							root_q <= (root_q >> 1) + bit_q;
						end else begin
							root_q <= root_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
				N_DLOAD: begin
					r_q     <= {3'b000, m_sel, 14'd0} + 47'(len >> 1);
					d_q     <= 47'(len) << 15;
					qt_q    <= '0;
					step_q  <= 4'd15;
					state_q <= N_DIV;
				end
				N_DIV: begin
					// restoring division, one quotient bit a cycle
					if (ge) begin
						r_q <= r_q - d_q;
					end
					d_q  <= d_q >> 1;
					qt_q <= qfull[14:0];
					if (step_q == '0) begin
						res_q[comp_q] <= neg_q[comp_q] ? OB'(-qclamp) : qclamp;
						if (comp_q == 2'd2) begin
							done    <= 1'b1;
							state_q <= N_IDLE;
						end else begin
							comp_q  <= comp_q + 2'd1;
							state_q <= N_DLOAD;
						end
					end else begin
						step_q <= step_q - 4'd1;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign q_x = res_q[0];
	assign q_y = res_q[1];
	assign q_z = res_q[2];

endmodule

`default_nettype wire

// ===== sv/smooth_vertex_normal_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_core
// area-weighted vertex normals: position store, saturating normal sums,
// resolve with normalisation to Q1.14
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start / busy       command, index_a/b/c, pos_x/y/z
//  result    done (one cycle)   vertex_index, norm_x/y/z, used_fallback
//
//  load leaves busy low; add triangle keeps busy high through three position
//  reads and three read-modify-write passes over the sum ram.
//  resolve of a zero sum raises done once the sum is read and cleared; otherwise
//  done waits for the one-bit-a-cycle scaling shifter, the 32-step
//  square root and three 16-step divisions.
//  after reset the sum ram is swept to zero, slot by slot, with busy high.
//  results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module smooth_vertex_normal_accumulator_core #(
	parameter int VERTEX_SLOTS = svna_pkg::VERTEX_SLOTS_DEF,
	parameter int COORD_BITS   = svna_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS     = svna_pkg::SUM_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [1:0]                            command,
	input  wire logic [svna_pkg::INDEX_BITS-1:0]       index_a,
	input  wire logic [svna_pkg::INDEX_BITS-1:0]       index_b,
	input  wire logic [svna_pkg::INDEX_BITS-1:0]       index_c,
	input  wire logic signed [15:0]                    pos_x,
	input  wire logic signed [15:0]                    pos_y,
	input  wire logic signed [15:0]                    pos_z,
	output logic                                       done,
	output logic [svna_pkg::INDEX_BITS-1:0]            vertex_index,
	output logic signed [svna_pkg::OUT_BITS-1:0]       norm_x,
	output logic signed [svna_pkg::OUT_BITS-1:0]       norm_y,
	output logic signed [svna_pkg::OUT_BITS-1:0]       norm_z,
	output logic                                       used_fallback
);

	localparam int AW  = $clog2(VERTEX_SLOTS);
	localparam int CB  = COORD_BITS;
	localparam int PW  = 3 * CB;
	localparam int NW  = 2 * CB + 3;
	localparam int SW  = 3 * SUM_BITS;
	localparam int W   = ((SUM_BITS > NW) ? SUM_BITS : NW) + 1;
	localparam int XW  = (CB > 16) ? CB : 16;
	localparam int IB  = svna_pkg::INDEX_BITS;
	localparam int OB  = svna_pkg::OUT_BITS;
	localparam int PRW = 2 * CB + 2;

	localparam logic signed [W-1:0] SMAX = {{(W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = ~SMAX;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PA, S_PB, S_PC, S_EDGE, S_MUL, S_CROSS,
		S_SRD, S_SWR, S_RRD, S_RWR, S_NWAIT
	} state_t;

	function automatic logic [AW-1:0] to_addr(input logic [IB-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[AW-1:0];
	endfunction

	function automatic logic in_rng(input logic [IB-1:0] i);
		return 32'(i) < 32'(VERTEX_SLOTS);
	endfunction

	function automatic logic signed [SUM_BITS-1:0] sat_add(
		input logic signed [SUM_BITS-1:0] a,
		input logic signed [NW-1:0]       b
	);
		logic signed [W-1:0] t;
		t = W'(a) + W'(b);
		if (t > SMAX) begin
			t = SMAX;
		end else if (t < SMIN) begin
			t = SMIN;
		end
		return t[SUM_BITS-1:0];
	endfunction

	state_t                state_q;
	logic [AW-1:0]         clr_cnt_q;
	logic [IB-1:0]         ia_q, ib_q, ic_q;
	logic                  rng_q;
	logic [1:0]            k_q;
	logic [PW-1:0]         pa_q, pb_q;
	logic signed [CB:0]    e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [2*CB+1:0] p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic signed [NW-1:0]  nx_q, ny_q, nz_q;

	// ram ports
	logic                  pos_we;
	logic [AW-1:0]         pos_waddr, pos_raddr;
	logic [PW-1:0]         pos_wdata, pos_rdata;
	logic                  sum_we;
	logic [AW-1:0]         sum_waddr, sum_raddr;
	logic [SW-1:0]         sum_wdata, sum_rdata;

	// normaliser
	logic                  norm_start, norm_done;
	logic signed [OB-1:0]  nq_x, nq_y, nq_z;

	logic                  accept;
	logic [IB-1:0]         idx_k;
	logic [XW-1:0]         px_w, py_w, pz_w;
	logic signed [SUM_BITS-1:0] sx, sy, sz;
	logic                  sum_zero;
	logic signed [CB-1:0]  ax, ay, az, bx, by, bz, cx, cy, cz;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// field unpacking and index selection
	always_comb begin
		px_w     = XW'($unsigned(pos_x));
		py_w     = XW'($unsigned(pos_y));
		pz_w     = XW'($unsigned(pos_z));
		sx       = sum_rdata[SUM_BITS-1:0];
		sy       = sum_rdata[2*SUM_BITS-1:SUM_BITS];
		sz       = sum_rdata[SW-1:2*SUM_BITS];
		sum_zero = (sx == '0) && (sy == '0) && (sz == '0);
		ax = pa_q[CB-1:0];  ay = pa_q[2*CB-1:CB];  az = pa_q[PW-1:2*CB];
		bx = pb_q[CB-1:0];  by = pb_q[2*CB-1:CB];  bz = pb_q[PW-1:2*CB];
		cx = pos_rdata[CB-1:0];
		cy = pos_rdata[2*CB-1:CB];
		cz = pos_rdata[PW-1:2*CB];
		case (k_q)
			2'd0:    idx_k = ia_q;
			2'd1:    idx_k = ib_q;
			default: idx_k = ic_q;
		endcase
	end

	// position store: written on load, read three times per triangle
	always_comb begin
		pos_we    = accept && (command == svna_pkg::CMD_LOAD) && in_rng(index_a);
		pos_waddr = to_addr(index_a);
		pos_wdata = {pz_w[CB-1:0], py_w[CB-1:0], px_w[CB-1:0]};
		case (state_q)
			S_PA:    pos_raddr = to_addr(ia_q);
			S_PB:    pos_raddr = to_addr(ib_q);
			default: pos_raddr = to_addr(ic_q);
		endcase
	end

	// sum store: clearing sweep, saturating accumulate, clear on resolve
	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = to_addr(idx_k);
		sum_wdata = '0;
		sum_raddr = (state_q == S_RRD) ? to_addr(ia_q) : to_addr(idx_k);
		case (state_q)
			S_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_cnt_q;
			end
			S_SWR: begin
				sum_we    = 1'b1;
				sum_wdata = {sat_add(sz, nz_q), sat_add(sy, ny_q), sat_add(sx, nx_q)};
			end
			S_RWR: begin
				sum_we    = rng_q;
				sum_waddr = to_addr(ia_q);
			end
			default: ;
		endcase
	end

	assign norm_start = (state_q == S_RWR) && rng_q && !sum_zero;

	// command sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			k_q       <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(VERTEX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						ia_q  <= index_a;
						ib_q  <= index_b;
						ic_q  <= index_c;
						rng_q <= in_rng(index_a);
						case (command)
							svna_pkg::CMD_ADD: begin
								if (in_rng(index_a) && in_rng(index_b) && in_rng(index_c)) begin
									state_q <= S_PA;
								end
							end
							svna_pkg::CMD_RESOLVE: state_q <= S_RRD;
							default: ;
						endcase
					end
				end
				S_PA: state_q <= S_PB;
				S_PB: begin
					pa_q    <= pos_rdata;
					state_q <= S_PC;
				end
				S_PC: begin
					pb_q    <= pos_rdata;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					e1x_s1  <= (CB+1)'(bx) - (CB+1)'(ax);
					e1y_s1  <= (CB+1)'(by) - (CB+1)'(ay);
					e1z_s1  <= (CB+1)'(bz) - (CB+1)'(az);
					e2x_s1  <= (CB+1)'(cx) - (CB+1)'(ax);
					e2y_s1  <= (CB+1)'(cy) - (CB+1)'(ay);
					e2z_s1  <= (CB+1)'(cz) - (CB+1)'(az);
					state_q <= S_MUL;
				end
				S_MUL: begin
					p_yz_s2 <= PRW'(e1y_s1) * PRW'(e2z_s1);
					p_zy_s2 <= PRW'(e1z_s1) * PRW'(e2y_s1);
					p_zx_s2 <= PRW'(e1z_s1) * PRW'(e2x_s1);
					p_xz_s2 <= PRW'(e1x_s1) * PRW'(e2z_s1);
					p_xy_s2 <= PRW'(e1x_s1) * PRW'(e2y_s1);
					p_yx_s2 <= PRW'(e1y_s1) * PRW'(e2x_s1);
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					nx_q    <= NW'(p_yz_s2) - NW'(p_zy_s2);
					ny_q    <= NW'(p_zx_s2) - NW'(p_xz_s2);
					nz_q    <= NW'(p_xy_s2) - NW'(p_yx_s2);
					k_q     <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					// next vertex is read only after this write lands
					if (k_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_SRD;
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					if (!rng_q || sum_zero) begin
						done          <= 1'b1;
						vertex_index  <= ia_q;
						norm_x        <= svna_pkg::UNIT_Q14;
						norm_y        <= '0;
						norm_z        <= '0;
						used_fallback <= 1'b1;
						state_q       <= S_IDLE;
					end else begin
						state_q <= S_NWAIT;
					end
				end
				S_NWAIT: begin
					if (norm_done) begin
						done          <= 1'b1;
						vertex_index  <= ia_q;
						norm_x        <= nq_x;
						norm_y        <= nq_y;
						norm_z        <= nq_z;
						used_fallback <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	svna_ram #(.WIDTH(PW), .DEPTH(VERTEX_SLOTS)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata (pos_wdata),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	svna_ram #(.WIDTH(SW), .DEPTH(VERTEX_SLOTS)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	svna_norm #(.SUM_BITS(SUM_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.sum_x  (sx),
		.sum_y  (sy),
		.sum_z  (sz),
		.done   (norm_done),
		.q_x    (nq_x),
		.q_y    (nq_y),
		.q_z    (nq_z)
	);

endmodule

`default_nettype wire

// ===== sv/svna_checker.sv =====
// ----------------------------------------------------------------------------
// svna_checker
// port-level checks of the accumulator core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module svna_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic [1:0]                        command,
	input wire logic                              done,
	input wire logic signed [svna_pkg::OUT_BITS-1:0] norm_x,
	input wire logic signed [svna_pkg::OUT_BITS-1:0] norm_y,
	input wire logic signed [svna_pkg::OUT_BITS-1:0] norm_z,
	input wire logic                              used_fallback
);

	// a word only follows work that kept the core busy
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without preceding busy cycle");

	// a load never produces a word
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == svna_pkg::CMD_LOAD) |=> !done)
		else $error("result word after a load");

	// fallback word is exactly the x unit vector
	a_fallback_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && used_fallback) |->
		(norm_x == svna_pkg::UNIT_Q14 && norm_y == '0 && norm_z == '0))
		else $error("fallback word is not (1,0,0)");

	// components stay within unit range
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (norm_x <= svna_pkg::UNIT_Q14 && norm_x >= -svna_pkg::UNIT_Q14 &&
			norm_y <= svna_pkg::UNIT_Q14 && norm_y >= -svna_pkg::UNIT_Q14 &&
			norm_z <= svna_pkg::UNIT_Q14 && norm_z >= -svna_pkg::UNIT_Q14))
		else $error("normal component out of range");

endmodule

bind smooth_vertex_normal_accumulator_core svna_checker u_svna_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.command       (command),
	.done          (done),
	.norm_x        (norm_x),
	.norm_y        (norm_y),
	.norm_z        (norm_z),
	.used_fallback (used_fallback)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the vertex normal accumulator against an in-bench predictor of the
// position store, the saturating face-normal sums and the Q1.14 normalisation
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int SLOTS      = svna_pkg::VERTEX_SLOTS_DEF;
	localparam int IB         = svna_pkg::INDEX_BITS;
	localparam longint SUM_HI = (64'sd1 <<< (svna_pkg::SUM_BITS_DEF - 1)) - 1;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [IB-1:0]         vtx;
		logic signed [15:0]    nx;
		logic signed [15:0]    ny;
		logic signed [15:0]    nz;
		logic                  fb;
	} normal_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] command;
	logic [IB-1:0] index_a, index_b, index_c;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic done;
	logic [IB-1:0] vertex_index;
	logic signed [svna_pkg::OUT_BITS-1:0] norm_x, norm_y, norm_z;
	logic used_fallback;

	// predictor state
	logic signed [15:0] vpos_x [SLOTS];
	logic signed [15:0] vpos_y [SLOTS];
	logic signed [15:0] vpos_z [SLOTS];
	bit                 vpos_loaded [SLOTS];
	longint             face_sum_x [SLOTS];
	longint             face_sum_y [SLOTS];
	longint             face_sum_z [SLOTS];
	int                 loaded_list [$];

	normal_word_t pending_normals [$];
	int  mismatches = 0;
	int  normals_seen = 0;
	int  words_sent = 0;
	int  cycles = 0;
	bit  gaps_on = 1'b1;

	smooth_vertex_normal_accumulator_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .index_a(index_a), .index_b(index_b), .index_c(index_c),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.done(done), .vertex_index(vertex_index), .norm_x(norm_x), .norm_y(norm_y),
		.norm_z(norm_z), .used_fallback(used_fallback)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("smooth_vertex_normal_accumulator_core verification failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic longint sat_sum(input longint acc, input longint delta);
		longint s;
		s = acc + delta;
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	// unit vector of a sum in Q1.14, or the fallback for a zero sum
	function automatic normal_word_t normalise_sum(input logic [IB-1:0] vtx,
			input longint sx, input longint sy, input longint sz);
		normal_word_t w;
		longint unsigned mx, my, mz, mm, sq, root, bitv, len, q;
		longint unsigned mags [3];
		bit negs [3];
		logic signed [15:0] outs [3];
		w.vtx = vtx;
		if (sx == 0 && sy == 0 && sz == 0) begin
			w.nx = svna_pkg::UNIT_Q14; w.ny = '0; w.nz = '0; w.fb = 1'b1;
			return w;
		end
		mx = sx < 0 ? -sx : sx;
		my = sy < 0 ? -sy : sy;
		mz = sz < 0 ? -sz : sz;
		mm = mx > my ? mx : my;
		if (mz > mm) mm = mz;
		while (mm >= (64'd1 << 30)) begin
			mx >>= 1; my >>= 1; mz >>= 1; mm >>= 1;
		end
		while (mm < (64'd1 << 29)) begin
			mx <<= 1; my <<= 1; mz <<= 1; mm <<= 1;
		end
		// bitwise integer square root
		sq = mx * mx + my * my + mz * mz;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > sq) bitv >>= 2;
		while (bitv != 0) begin
			if (sq >= root + bitv) begin
				sq -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		len = root;
		mags[0] = mx; mags[1] = my; mags[2] = mz;
		negs[0] = sx < 0; negs[1] = sy < 0; negs[2] = sz < 0;
		for (int k = 0; k < 3; k++) begin
			q = (mags[k] * 16384 + (len >> 1)) / len;
			if (q > 16384) q = 16384;
			outs[k] = negs[k] ? -$signed(16'(q)) : $signed(16'(q));
		end
		w.nx = outs[0]; w.ny = outs[1]; w.nz = outs[2]; w.fb = 1'b0;
		return w;
	endfunction

	// update predictor for one accepted word
	task automatic apply_command(input logic [1:0] cmd, input int a, input int b,
			input int c, input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		longint e1x, e1y, e1z, e2x, e2y, e2z, fx, fy, fz;
		int tri_idx [3];
		case (cmd)
			svna_pkg::CMD_LOAD: begin
				vpos_x[a] = x; vpos_y[a] = y; vpos_z[a] = z;
				if (!vpos_loaded[a]) loaded_list.insert(loaded_list.size(), a);
				vpos_loaded[a] = 1'b1;
			end
			svna_pkg::CMD_ADD: begin
				e1x = vpos_x[b] - vpos_x[a]; e1y = vpos_y[b] - vpos_y[a];
				e1z = vpos_z[b] - vpos_z[a];
				e2x = vpos_x[c] - vpos_x[a]; e2y = vpos_y[c] - vpos_y[a];
				e2z = vpos_z[c] - vpos_z[a];
				fx = e1y * e2z - e1z * e2y;
				fy = e1z * e2x - e1x * e2z;
				fz = e1x * e2y - e1y * e2x;
				tri_idx[0] = a; tri_idx[1] = b; tri_idx[2] = c;
				foreach (tri_idx[k]) begin
					face_sum_x[tri_idx[k]] = sat_sum(face_sum_x[tri_idx[k]], fx);
					face_sum_y[tri_idx[k]] = sat_sum(face_sum_y[tri_idx[k]], fy);
					face_sum_z[tri_idx[k]] = sat_sum(face_sum_z[tri_idx[k]], fz);
				end
			end
			svna_pkg::CMD_RESOLVE: begin
				pending_normals.insert(pending_normals.size(), normalise_sum(a[IB-1:0],
					face_sum_x[a], face_sum_y[a], face_sum_z[a]));
				face_sum_x[a] = 0; face_sum_y[a] = 0; face_sum_z[a] = 0;
			end
			default: ;
		endcase
	endtask

	// drive one command word and wait until it is taken
	task automatic send_word(input logic [1:0] cmd, input int a, input int b = 0,
			input int c = 0, input logic signed [15:0] x = '0,
			input logic signed [15:0] y = '0, input logic signed [15:0] z = '0);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		command <= cmd;
		index_a <= a[IB-1:0]; index_b <= b[IB-1:0]; index_c <= c[IB-1:0];
		pos_x <= x; pos_y <= y; pos_z <= z;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		words_sent++;
		apply_command(cmd, a, b, c, x, y, z);
	endtask

	task automatic wait_for_normals();
		start <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $signed(16'($urandom));
			1: return $signed(16'($urandom_range(0, 1))) ? 16'sh7fff : 16'sh8000;
			default: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		normal_word_t w;
		if (arst_n && done === 1'b1) begin
			normals_seen++;
			if (pending_normals.size() == 0) begin
				report_mismatch($sformatf("unexpected word for vertex %0d", vertex_index));
			end else begin
				w = pending_normals.pop_front();
				if (vertex_index !== w.vtx)
					report_mismatch($sformatf("vertex_index %0d, want %0d", vertex_index, w.vtx));
				if (norm_x !== w.nx)
					report_mismatch($sformatf("vtx %0d norm_x %0d, want %0d", w.vtx, norm_x, w.nx));
				if (norm_y !== w.ny)
					report_mismatch($sformatf("vtx %0d norm_y %0d, want %0d", w.vtx, norm_y, w.ny));
				if (norm_z !== w.nz)
					report_mismatch($sformatf("vtx %0d norm_z %0d, want %0d", w.vtx, norm_z, w.nz));
				if (used_fallback !== w.fb)
					report_mismatch($sformatf("vtx %0d used_fallback %0b, want %0b", w.vtx,
						used_fallback, w.fb));
			end
		end
	end

	// extremes, every command, fallback, degenerate face, unused code
	task automatic test_directed();
		send_word(svna_pkg::CMD_RESOLVE, 5);
		send_word(svna_pkg::CMD_LOAD, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(svna_pkg::CMD_LOAD, 1, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_word(svna_pkg::CMD_LOAD, 1023, 0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff);
		send_word(svna_pkg::CMD_LOAD, 2, 0, 0, 16'sd256, 16'sd0, -16'sd256);
		send_word(svna_pkg::CMD_ADD, 0, 1, 1023);
		send_word(svna_pkg::CMD_ADD, 1023, 2, 0);
		send_word(svna_pkg::CMD_ADD, 2, 2, 2);
		send_word(CMD_UNUSED, 1023, 1023, 1023, 16'shffff, 16'shffff, 16'shffff);
		send_word(svna_pkg::CMD_RESOLVE, 0);
		send_word(svna_pkg::CMD_RESOLVE, 1);
		send_word(svna_pkg::CMD_RESOLVE, 1023);
		send_word(svna_pkg::CMD_RESOLVE, 2);
		send_word(svna_pkg::CMD_RESOLVE, 1023);
		send_word(svna_pkg::CMD_ADD, 1, 1, 0);
		send_word(svna_pkg::CMD_RESOLVE, 1);
		send_word(svna_pkg::CMD_RESOLVE, 682, 341, 1023);
	endtask

	// one big face repeated to build large sums of both signs
	task automatic test_large_sums();
		send_word(svna_pkg::CMD_LOAD, 10, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(svna_pkg::CMD_LOAD, 11, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000);
		send_word(svna_pkg::CMD_LOAD, 12, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
		repeat (150) send_word(svna_pkg::CMD_ADD, 10, 11, 12);
		send_word(svna_pkg::CMD_RESOLVE, 10);
		send_word(svna_pkg::CMD_ADD, 12, 11, 10);
		send_word(svna_pkg::CMD_RESOLVE, 11);
		send_word(svna_pkg::CMD_RESOLVE, 12);
	endtask

	// random meshes: loads, faces over loaded vertices, resolves, some noise
	task automatic test_random_mesh(input int n_words);
		int pick, a, b, c;
		for (int i = 0; i < n_words; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 20 || loaded_list.size() < 3) begin
				send_word(svna_pkg::CMD_LOAD, $urandom_range(0, SLOTS - 1), $urandom,
					$urandom, rand_coord(), rand_coord(), rand_coord());
			end else if (pick < 70) begin
				a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				b = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				send_word(svna_pkg::CMD_ADD, a, b, c, 16'($urandom), 16'($urandom),
					16'($urandom));
			end else if (pick < 95) begin
				a = ($urandom_range(0, 3) != 0) ?
					loaded_list[$urandom_range(0, loaded_list.size() - 1)] :
					$urandom_range(0, SLOTS - 1);
				send_word(svna_pkg::CMD_RESOLVE, a, $urandom, $urandom, 16'($urandom),
					16'($urandom), 16'($urandom));
			end else begin
				send_word(CMD_UNUSED, $urandom, $urandom, $urandom, 16'($urandom),
					16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		command = svna_pkg::CMD_LOAD;
		index_a = '0; index_b = '0; index_c = '0;
		pos_x = '0; pos_y = '0; pos_z = '0;
		for (int i = 0; i < SLOTS; i++) begin
			vpos_loaded[i] = 1'b0;
			face_sum_x[i] = 0; face_sum_y[i] = 0; face_sum_z[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_large_sums();
		wait_for_normals();
		test_random_mesh(1300);
		gaps_on = 1'b0;
		test_random_mesh(400);

		wait_for_normals();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d command words, checked %0d normal words", words_sent, normals_seen);
		$display("covered extreme coordinates, large sums, zero-sum fallback and random meshes");
		if (mismatches == 0 && pending_normals.size() == 0) begin
			$display("smooth_vertex_normal_accumulator_core verification clean");
		end else begin
			$display("%0d mismatches, %0d words outstanding", mismatches,
				pending_normals.size());
			$display("smooth_vertex_normal_accumulator_core verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
